### design/circular_deque_indexed_top_macros.svh
// Assertion macros used by the deque controller RTL.
// Users must have clk and rst_n (synchronous, active low) in scope.
`ifndef CIRCULAR_DEQUE_INDEXED_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_INDEXED_TOP_MACROS_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define CDQ_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("%m: assertion failed");

// Whenever cond holds, prop must hold in the next cycle.
`define CDQ_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("%m: assertion failed");

`endif

### design/cdq_pkg.sv
// Shared types for the indexed circular deque.
// No dependencies; imported by the controller, the top level and the testbench.
package cdq_pkg;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_REMOVE = 2'd1,
    K_GET    = 2'd2,
    K_SET    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic    load;
    status_t status;
  } res_ctl_t;

endpackage

### design/cdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/cdq_ctrl.sv
// Deque controller: decodes an item, sequences the word moves through the RAM
// and keeps the front pointer and count. Depends on cdq_pkg and the macro header.
`include "circular_deque_indexed_top_macros.svh"

module cdq_ctrl #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_kind,
  input  logic [$clog2(CAPACITY+1)-1:0]   in_position,
  input  logic [WORD_BITS-1:0]            in_data_in,
  input  logic                            out_free,
  output cdq_pkg::res_ctl_t               res_ctl,
  output logic [WORD_BITS-1:0]            res_data,
  output logic [$clog2(CAPACITY+1)-1:0]   res_count,
  output logic                            ram_we,
  output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
  output logic [WORD_BITS-1:0]            ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(CAPACITY)-1:0]     ram_raddr,
  input  logic [WORD_BITS-1:0]            ram_rdata
);
  import cdq_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] POS_NEG1 = {CNT_W{1'b1}};

  // Slot of base + off, where the sum stays below twice the capacity.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     held_count_r, held_count_nxt;
  logic [PTR_W-1:0]     front_r, front_nxt;
  logic                 cap_r, cap_nxt;
  logic                 pend_r, pend_nxt;
  logic [PTR_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0]     moves_r, moves_nxt;
  logic [PTR_W-1:0]     dst_r, dst_nxt;
  logic                 up_r, up_nxt;
  logic [PTR_W-1:0]     tgt_r, tgt_nxt;
  logic                 fin_wr_r, fin_wr_nxt;
  logic [PTR_W-1:0]     new_front_r, new_front_nxt;
  logic [CNT_W-1:0]     new_count_r, new_count_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;
  status_t              status_r, status_nxt;

  // Decode of the incoming item against the current count and front.
  kind_t            kind;
  status_t          d_status;
  logic             d_ins, d_rem, d_fetch, d_setw;
  logic [CNT_W-1:0] ins_pos;
  logic             front_ins, front_rem;
  logic [PTR_W-1:0] f_dec, f_inc;
  logic [CNT_W-1:0] p_moves, p_count;
  logic [PTR_W-1:0] p_dst, p_tgt, p_front;
  logic             p_up;

  always_comb begin
    kind     = kind_t'(in_kind);
    d_status = ST_OK;
    d_ins    = 1'b0;
    d_rem    = 1'b0;
    d_fetch  = 1'b0;
    d_setw   = 1'b0;
    ins_pos  = in_position;
    unique case (kind)
      K_INSERT: begin
        if (held_count_r == CAP_CNT) begin
          d_status = ST_FULL;
        end else if (in_position > held_count_r) begin
          d_status = ST_BADIDX;
        end else begin
          d_ins = 1'b1;
        end
      end
      K_REMOVE: begin
        if (held_count_r == '0) begin
          d_status = ST_EMPTY;
        end else if (in_position >= held_count_r) begin
          d_status = ST_BADIDX;
        end else begin
          d_rem   = 1'b1;
          d_fetch = 1'b1;
        end
      end
      K_GET: begin
        if (in_position >= held_count_r) begin
          d_status = ST_BADIDX;
        end else begin
          d_fetch = 1'b1;
        end
      end
      K_SET: begin
        if (in_position < held_count_r) begin
          d_fetch = 1'b1;
          d_setw  = 1'b1;
        end else if (in_position == held_count_r || in_position == POS_NEG1) begin
          if (held_count_r == CAP_CNT) begin
            d_status = ST_FULL;
          end else begin
            d_ins   = 1'b1;
            ins_pos = (in_position == POS_NEG1) ? '0 : held_count_r;
          end
        end else begin
          d_status = ST_BADIDX;
        end
      end
    endcase

    // Shift the front side only when strictly fewer words lie in front.
    front_ins = {ins_pos, 1'b0} < {1'b0, held_count_r};
    front_rem = {in_position, 1'b1} < {1'b0, held_count_r};
    f_dec     = ptr_dec(front_r);
    f_inc     = ptr_inc(front_r);

    p_moves = '0;
    p_dst   = front_r;
    p_up    = 1'b0;
    p_tgt   = wrap_add(front_r, in_position);
    p_front = front_r;
    p_count = held_count_r;
    if (d_ins) begin
      p_count = held_count_r + 1'b1;
      if (front_ins) begin
        p_moves = ins_pos;
        p_dst   = f_dec;
        p_up    = 1'b1;
        p_tgt   = wrap_add(f_dec, ins_pos);
        p_front = f_dec;
      end else begin
        p_moves = held_count_r - ins_pos;
        p_dst   = wrap_add(front_r, held_count_r);
        p_up    = 1'b0;
        p_tgt   = wrap_add(front_r, ins_pos);
      end
    end
    if (d_rem) begin
      p_count = held_count_r - 1'b1;
      p_dst   = wrap_add(front_r, in_position);
      if (front_rem) begin
        p_moves = in_position;
        p_up    = 1'b0;
        p_front = f_inc;
      end else begin
        p_moves = held_count_r - 1'b1 - in_position;
        p_up    = 1'b1;
      end
      if (held_count_r == CNT_W'(1)) begin
        p_front = '0;
      end
    end
  end

  // Sequencer. Moves are pipelined: the read of one move overlaps the write
  // of the previous. A move reads only slots not yet written in this item,
  // so no forwarding is needed.
  always_comb begin
    state_nxt      = state_r;
    held_count_nxt = held_count_r;
    front_nxt      = front_r;
    cap_nxt        = cap_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    moves_nxt      = moves_r;
    dst_nxt        = dst_r;
    up_nxt         = up_r;
    tgt_nxt        = tgt_r;
    fin_wr_nxt     = fin_wr_r;
    new_front_nxt  = new_front_r;
    new_count_nxt  = new_count_r;
    word_nxt       = word_r;
    data_nxt       = data_r;
    status_nxt     = status_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = tgt_r;
    res_ctl.load   = 1'b0;
    res_ctl.status = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          status_nxt    = d_status;
          moves_nxt     = p_moves;
          dst_nxt       = p_dst;
          up_nxt        = p_up;
          tgt_nxt       = p_tgt;
          fin_wr_nxt    = d_ins | d_setw;
          new_front_nxt = p_front;
          new_count_nxt = p_count;
          word_nxt      = in_data_in;
          data_nxt      = '0;
          cap_nxt       = 1'b0;
          pend_nxt      = 1'b0;
          if (d_status != ST_OK) begin
            state_nxt = S_FINAL;
          end else if (d_fetch) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = tgt_r;
        cap_nxt   = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (cap_r) begin
          data_nxt = ram_rdata;
        end
        cap_nxt = 1'b0;
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r;
          ram_wdata = ram_rdata;
        end
        if (moves_r != '0) begin
          ram_re        = 1'b1;
          ram_raddr     = up_r ? ptr_inc(dst_r) : ptr_dec(dst_r);
          pend_nxt      = 1'b1;
          pend_addr_nxt = dst_r;
          dst_nxt       = ram_raddr;
          moves_nxt     = moves_r - 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          if (fin_wr_r) begin
            ram_we    = 1'b1;
            ram_waddr = tgt_r;
            ram_wdata = word_r;
          end
          held_count_nxt = new_count_r;
          front_nxt      = new_front_r;
          res_ctl.load   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_count_r <= '0;
      front_r      <= '0;
      cap_r        <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_count_r <= held_count_nxt;
      front_r      <= front_nxt;
      cap_r        <= cap_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    moves_r     <= moves_nxt;
    dst_r       <= dst_nxt;
    up_r        <= up_nxt;
    tgt_r       <= tgt_nxt;
    fin_wr_r    <= fin_wr_nxt;
    new_front_r <= new_front_nxt;
    new_count_r <= new_count_nxt;
    word_r      <= word_nxt;
    data_r      <= data_nxt;
    status_r    <= status_nxt;
  end

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign res_data  = data_r;
  assign res_count = new_count_r;

  `CDQ_ASSERT_IMPL(a_count_range, 1'b1, held_count_r <= CAP_CNT)
  `CDQ_ASSERT_IMPL(a_empty_front, held_count_r == '0, front_r == '0)
  `CDQ_ASSERT_IMPL(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
  `CDQ_ASSERT_NEXT(a_count_hold, state_r != S_FINAL, $stable(held_count_r))
  `CDQ_ASSERT_IMPL(a_cap_no_pend, cap_r, !pend_r)

endmodule

### design/circular_deque_indexed_top.sv
// Indexed circular deque: a fixed-capacity deque of words held in one RAM.
//
// Input channel (in_valid / in_stall): each item carries an operation kind
// (insert, remove, get, set), a logical position counted from the front, and
// a data word. An item is taken on a clock edge with in_valid high and
// in_stall low. Output channel (out_valid / out_stall): one result item per
// input item with the removed, read or replaced word, a status code and the
// count of words held afterwards.
//
// Items are processed one at a time. A rejected item goes straight to its result,
// a get or a replacing set first reads its word, an insert moves m words, and a
// remove reads its word and then moves m, where m is at most CAPACITY/2. The move
// count sets the pace: each moved word needs a write on the single write port.
//
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the next item completes its moves and then
// holds in its last step until the output register frees.
//
// Reset (synchronous, active low) empties the deque and sets the front
// pointer to zero. Slot contents are not cleared; only held words are read.
module circular_deque_indexed_top #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [$clog2(CAPACITY+1)-1:0] in_position,
  input  logic [WORD_BITS-1:0]          in_data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [WORD_BITS-1:0]          out_data_out,
  output logic [1:0]                    out_status,
  output logic [$clog2(CAPACITY+1)-1:0] out_count
);
  import cdq_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  res_ctl_t             res_ctl;
  logic [WORD_BITS-1:0] res_data;
  logic [CNT_W-1:0]     res_count;
  logic                 out_free;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Output register state.
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_data_r;
  status_t              out_status_r;
  logic [CNT_W-1:0]     out_count_r;

  cdq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cdq_ctrl #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_position (in_position),
    .in_data_in  (in_data_in),
    .out_free    (out_free),
    .res_ctl     (res_ctl),
    .res_data    (res_data),
    .res_count   (res_count),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // The output register can take a new result when empty or when its
  // current item leaves on this edge.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_ctl.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ctl.load) begin
      out_data_r   <= res_data;
      out_status_r <= res_ctl.status;
      out_count_r  <= res_count;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

endmodule

### sim/circular_deque_indexed_top_tb.sv
// Self-checking testbench for the indexed circular deque (circular_deque_indexed_top).
// Depends on cdq_pkg for the operation and status codes and on the deque design files.
// A shadow deque predicts every result, which is compared in order as it is taken.
module circular_deque_indexed_top_tb;
  import cdq_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int WORD_BITS  = 32;
  localparam int POS_BITS   = $clog2(CAPACITY + 1);
  localparam int FRONT_BITS = $clog2(CAPACITY);

  // A set at this position means index -1, an insert at the front.
  localparam logic [POS_BITS-1:0] POS_FRONT = '1;

  // Longest item: a remove that moves half the words, plus some margin.
  localparam int SETTLE_CYCLES = 4 + CAPACITY / 2 + 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 600;
  localparam int MAX_REPORTS   = 100;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    status_t              status;
    logic [POS_BITS-1:0]  count;
  } deque_result_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_kind     = '0;
  logic [POS_BITS-1:0]  in_position = '0;
  logic [WORD_BITS-1:0] in_data_in  = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [WORD_BITS-1:0] out_data_out;
  logic [1:0]           out_status;
  logic [POS_BITS-1:0]  out_count;

  // Shadow copy of the deque contents and pointers.
  logic [WORD_BITS-1:0]  shadow_slots [CAPACITY];
  logic [FRONT_BITS-1:0] shadow_front;
  logic [POS_BITS-1:0]   shadow_count;

  deque_result_t pending_results [$];
  int            mismatch_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            filling;

  circular_deque_indexed_top #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_position (in_position),
    .in_data_in  (in_data_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data_out(out_data_out),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow deque. Logical index i sits in slot (front + i) mod CAPACITY.
  // ---------------------------------------------------------------------------
  function automatic logic [FRONT_BITS-1:0] slot_of(int idx);
    return FRONT_BITS'((int'(shadow_front) + idx) % CAPACITY);
  endfunction

  // Opens a hole at logical index p by moving the shorter side, then fills it.
  function automatic void shadow_insert(int p, logic [WORD_BITS-1:0] word);
    int n;
    n = int'(shadow_count);
    if (p < n - p) begin
      shadow_front = FRONT_BITS'((int'(shadow_front) + CAPACITY - 1) % CAPACITY);
      for (int i = 0; i < p; i++) shadow_slots[slot_of(i)] = shadow_slots[slot_of(i + 1)];
    end else begin
      for (int i = n; i > p; i--) shadow_slots[slot_of(i)] = shadow_slots[slot_of(i - 1)];
    end
    shadow_slots[slot_of(p)] = word;
    shadow_count = shadow_count + 1'b1;
  endfunction

  // Closes the gap at logical index p from the shorter side.
  function automatic logic [WORD_BITS-1:0] shadow_remove(int p);
    int                   n;
    logic [WORD_BITS-1:0] word;
    n    = int'(shadow_count);
    word = shadow_slots[slot_of(p)];
    if (p < n - 1 - p) begin
      for (int i = p; i > 0; i--) shadow_slots[slot_of(i)] = shadow_slots[slot_of(i - 1)];
      shadow_front = FRONT_BITS'((int'(shadow_front) + 1) % CAPACITY);
    end else begin
      for (int i = p; i + 1 < n; i++) shadow_slots[slot_of(i)] = shadow_slots[slot_of(i + 1)];
    end
    shadow_count = shadow_count - 1'b1;
    if (shadow_count == 0) shadow_front = '0;
    return word;
  endfunction

  // Applies one operation to the shadow deque and returns the result it should give.
  function automatic deque_result_t apply_deque_op(kind_t kind, logic [POS_BITS-1:0] pos,
                                                    logic [WORD_BITS-1:0] word);
    deque_result_t res;
    int            n;
    int            p;
    res.word   = '0;
    res.status = ST_OK;
    n = int'(shadow_count);
    p = int'(pos);
    case (kind)
      K_INSERT: begin
        if (n >= CAPACITY) res.status = ST_FULL;
        else if (p > n) res.status = ST_BADIDX;
        else shadow_insert(p, word);
      end
      K_REMOVE: begin
        if (n == 0) res.status = ST_EMPTY;
        else if (p >= n) res.status = ST_BADIDX;
        else res.word = shadow_remove(p);
      end
      K_GET: begin
        if (p >= n) res.status = ST_BADIDX;
        else res.word = shadow_slots[slot_of(p)];
      end
      default: begin
        if (p < n) begin
          res.word = shadow_slots[slot_of(p)];
          shadow_slots[slot_of(p)] = word;
        end else if (p == n || pos == POS_FRONT) begin
          if (n >= CAPACITY) res.status = ST_FULL;
          else shadow_insert((pos == POS_FRONT) ? 0 : n, word);
        end else begin
          res.status = ST_BADIDX;
        end
      end
    endcase
    res.count = shadow_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall and in-order comparison against the shadow.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                 logic [WORD_BITS-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, data", out_data_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.word) report_mismatch("data_out", out_data_out, want.word);
        if (out_status !== want.status)
          report_mismatch("status", WORD_BITS'(out_status), WORD_BITS'(want.status));
        if (out_count !== want.count)
          report_mismatch("count", WORD_BITS'(out_count), WORD_BITS'(want.count));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_n);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one item after a random gap and predicts its result once it is taken.
  task automatic send_op(kind_t kind, logic [POS_BITS-1:0] pos, logic [WORD_BITS-1:0] word);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_data_in  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_deque_op(kind, pos, word));
  endtask

  // Holds the sender until every pending result is back and the block has settled.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Operations on an empty deque are all refused.
  task automatic test_empty_store();
    send_op(K_REMOVE, POS_BITS'(0), 32'h1234_5678);
    send_op(K_GET, POS_BITS'(0), '0);
    send_op(K_INSERT, POS_BITS'(1), '1);
    send_op(K_SET, POS_BITS'(5), '1);
  endtask

  // Set at -1 and at count insert at the two ends; set below count replaces.
  task automatic test_end_inserts();
    send_op(K_SET, POS_FRONT, '1);
    send_op(K_SET, POS_BITS'(1), '0);
    send_op(K_SET, POS_BITS'(0), 32'hA5A5_A5A5);
    send_op(K_GET, POS_BITS'(1), '0);
  endtask

  // Middle inserts that shift the front side as well as the back side, up to full.
  task automatic test_fill_to_capacity();
    int positions [14] = '{1, 0, 2, 4, 1, 3, 6, 8, 0, 5, 11, 7, 13, 15};
    foreach (positions[j]) send_op(K_INSERT, POS_BITS'(positions[j]), $urandom);
  endtask

  // A full deque refuses every kind of insert; an index of CAPACITY is out of range.
  task automatic test_full_store();
    send_op(K_INSERT, POS_BITS'(0), '1);
    send_op(K_SET, POS_BITS'(CAPACITY), '1);
    send_op(K_SET, POS_FRONT, '0);
    send_op(K_REMOVE, POS_BITS'(CAPACITY), '0);
  endtask

  // Picks a position: mostly a legal one for the operation, sometimes any value.
  function automatic logic [POS_BITS-1:0] pick_position(kind_t kind);
    int r;
    int n;
    r = $urandom_range(99);
    n = int'(shadow_count);
    if (r < 10) return POS_BITS'($urandom_range(2 ** POS_BITS - 1));
    if (r < 20 && kind == K_SET) return POS_FRONT;
    if (kind == K_INSERT || kind == K_SET || n == 0) return POS_BITS'($urandom_range(n));
    return POS_BITS'($urandom_range(n - 1));
  endfunction

  // The deque alternates between filling and draining so that its count sweeps
  // the whole range and both full and empty are reached again and again.
  task automatic test_random_ops(int items);
    kind_t                kind;
    int                   r;
    logic [WORD_BITS-1:0] word;
    repeat (items) begin
      if (shadow_count == CAPACITY) filling = 1'b0;
      else if (shadow_count == 0) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = !filling;
      r = $urandom_range(99);
      if (r < 45) kind = filling ? K_INSERT : K_REMOVE;
      else if (r < 60) kind = filling ? K_REMOVE : K_INSERT;
      else if (r < 80) kind = K_GET;
      else kind = K_SET;
      r = $urandom_range(99);
      if (r < 10) word = '0;
      else if (r < 20) word = '1;
      else word = $urandom;
      send_op(kind, pick_position(kind), word);
    end
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct  = 23;
    recv_idle_pct  = 56;
    filling        = 1'b1;
    shadow_front   = '0;
    shadow_count   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_end_inserts();
    test_fill_to_capacity();
    test_full_store();
    wait_for_results();

    test_random_ops(PHASE_ITEMS);
    wait_for_results();
    send_idle_pct = 56;
    recv_idle_pct = 23;
    test_random_ops(PHASE_ITEMS);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(PHASE_ITEMS);
    wait_for_results();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### circular_deque_indexed_top.f
+incdir+design
design/cdq_pkg.sv
design/cdq_ram.sv
design/cdq_ctrl.sv
design/circular_deque_indexed_top.sv
sim/circular_deque_indexed_top_tb.sv
